[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSE_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg
// Shared widths, operation and status codes, and the command and status
// groups that pass between the stack controller and its datapath.
// ----------------------------------------------------------------------------
package bse_pkg;

   // Default built depth of the stack storage.
   localparam int DEPTH_DEFAULT = 64;

   // Fixed field widths.
   localparam int CAP_W    = 7;
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;

   // Capacity register value after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
   localparam logic [OP_W-1:0] OP_POP    = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
   localparam logic [OP_W-1:0] OP_DUMP   = 3'd3;
   localparam logic [OP_W-1:0] OP_CHANGE = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADINDEX = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;        // capture the request word
      logic                push;        // store value on top, grow by one
      logic                pop;         // shrink by one
      logic                change;      // overwrite entry at index
      logic                rd_first;    // read the top entry
      logic                rd_next;     // read the entry below the pointer
      logic                emit;        // load the response register
      logic                emit_data;   // response data comes from storage
      logic                emit_last;   // response closes the run
      logic [STATUS_W-1:0] emit_status; // response status code
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [OP_W-1:0] op;        // captured operation
      logic            full;      // no room under the effective capacity
      logic            empty;     // no stored entries
      logic            idx_ok;    // captured index names a stored entry
      logic            ptr_zero;  // read pointer sits on the bottom entry
      logic            out_free;  // response register can take a word
   } sts_type;

endpackage

[rtl/core/bse_ram.sv]
// ----------------------------------------------------------------------------
// bse_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; read data holds between reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bse_dp.sv]
// ----------------------------------------------------------------------------
// bse_dp
// Stack datapath: request capture, fill count, capacity register, storage,
// read pointer and the response register.
// ----------------------------------------------------------------------------
module bse_dp #(
   parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bse_pkg::cmd_type              cmd,
   output bse_pkg::sts_type              sts,
   input  logic [bse_pkg::OP_W-1:0]      req_op,
   input  logic [bse_pkg::VALUE_W-1:0]   req_value,
   input  logic [bse_pkg::INDEX_W-1:0]   req_index,
   input  logic                          csr_wen,
   input  logic [bse_pkg::CAP_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bse_pkg::VALUE_W-1:0]   rsp_data,
   output logic [bse_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > bse_pkg::INDEX_W) ? FW : bse_pkg::INDEX_W;
   localparam int KW = (FW > bse_pkg::CAP_W) ? FW : bse_pkg::CAP_W;

   logic [bse_pkg::OP_W-1:0]     op_ff;
   logic [bse_pkg::VALUE_W-1:0]  value_ff;
   logic [bse_pkg::INDEX_W-1:0]  index_ff;
   logic [bse_pkg::CAP_W-1:0]    cap_ff;
   logic [FW-1:0]                fill_ff;
   logic [FW-1:0]                fill_in;
   logic [AW-1:0]                ptr_ff;
   logic [AW-1:0]                ptr_in;
   logic                         rsp_valid_ff;
   logic [bse_pkg::VALUE_W-1:0]  rsp_data_ff;
   logic [bse_pkg::STATUS_W-1:0] rsp_status_ff;
   logic                         rsp_last_ff;

   logic [FW-1:0]                fill_dec;
   logic [CW-1:0]                idx_ext;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [bse_pkg::VALUE_W-1:0]  rd_data;

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_value;
         index_ff <= req_index;
      end
   end

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= bse_pkg::CAP_RESET;
      end else if (csr_wen) begin
         cap_ff <= csr_wdata;
      end
   end

   // Fill count and read pointer.
   assign fill_dec = fill_ff - FW'(1);
   assign idx_ext  = CW'(index_ff);

   always_comb begin
      fill_in = fill_ff;
      if (cmd.push) begin
         fill_in = fill_ff + FW'(1);
      end else if (cmd.pop) begin
         fill_in = fill_dec;
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.rd_first) begin
         ptr_in = fill_dec[AW-1:0];
      end else if (cmd.rd_next) begin
         ptr_in = ptr_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
      ptr_ff <= ptr_in;
   end

   // Storage: push writes on top, change writes at the captured index.
   assign wr_en   = cmd.push | cmd.change;
   assign wr_addr = cmd.push ? fill_ff[AW-1:0] : idx_ext[AW-1:0];
   assign rd_en   = cmd.rd_first | cmd.rd_next;
   assign rd_addr = ptr_in;

   bse_ram #(
      .WIDTH (bse_pkg::VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response register; it frees up in the cycle its word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff   <= cmd.emit_data ? rd_data : '0;
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // Status toward the controller.
   assign sts.op       = op_ff;
   assign sts.full     = (KW'(fill_ff) >= KW'(cap_ff)) || (fill_ff == FW'(DEPTH));
   assign sts.empty    = (fill_ff == '0);
   assign sts.idx_ok   = (idx_ext < CW'(fill_ff));
   assign sts.ptr_zero = (ptr_ff == '0);
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;

endmodule

[rtl/core/bse_ctrl.sv]
// ----------------------------------------------------------------------------
// bse_ctrl
// Stack controller: takes one request word at a time, decodes the operation
// and sequences the datapath through execution and storage reads.
// ----------------------------------------------------------------------------
module bse_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  bse_pkg::sts_type sts,
   output bse_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Only a single request is held at a time.
   assign req_tready = (state_ff == S_IDLE);

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.load = req_tvalid & req_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.out_free) begin
               state_in      = S_IDLE;
               cmd.emit_last = 1'b1;
               case (sts.op)
                  bse_pkg::OP_PUSH: begin
                     cmd.emit        = 1'b1;
                     cmd.push        = ~sts.full;
                     cmd.emit_status = sts.full ? bse_pkg::ST_OVERFLOW : bse_pkg::ST_OK;
                  end
                  bse_pkg::OP_POP: begin
                     cmd.emit        = 1'b1;
                     cmd.pop         = ~sts.empty;
                     cmd.emit_status = sts.empty ? bse_pkg::ST_EMPTY : bse_pkg::ST_OK;
                  end
                  bse_pkg::OP_CHANGE: begin
                     cmd.emit        = 1'b1;
                     cmd.change      = sts.idx_ok;
                     cmd.emit_status = sts.idx_ok ? bse_pkg::ST_OK : bse_pkg::ST_BADINDEX;
                  end
                  bse_pkg::OP_PEEK, bse_pkg::OP_DUMP: begin
                     // An empty stack answers at once; otherwise read the top.
                     if (sts.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = bse_pkg::ST_EMPTY;
                     end else begin
                        cmd.rd_first = 1'b1;
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                     // Undefined operations give no result.
                     cmd.emit_last = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            // One stored word goes out per free response slot.
            if (sts.out_free) begin
               cmd.emit        = 1'b1;
               cmd.emit_data   = 1'b1;
               cmd.emit_status = bse_pkg::ST_OK;
               cmd.emit_last   = (sts.op != bse_pkg::OP_DUMP) | sts.ptr_zero;
               if (cmd.emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/bounded_stack_engine_core.sv]
// ----------------------------------------------------------------------------
// bounded_stack_engine_core
// Bounded LIFO stack of signed 32-bit words with push, pop, peek, dump and
// indexed change, and a programmable capacity.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Contents
//  req      in         tvalid / tready    tuser op, tdata value and index
//  rsp      out        tvalid / tready    tuser status, tdata data, tlast
//  csr      in         csr_wen            capacity
//
//  Push, pop and change: the request is captured, then the execution state loads the result word.
//  Peek: the top entry is read through the registered read port of the storage RAM, then emitted.
//  Dump: one RAM read per stored word, from the top entry down.
//  One request is held at a time; the next is taken once the last result
//  word of the current one sits in the response register. A stalled
//  response register holds execution. Reset empties the stack and sets the
//  capacity to 64; storage contents are not cleared, and no clearing pass runs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_stack_engine_core #(
   parameter int DEPTH = bse_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [39:0]                  req_tdata,  // value [31:0], index [37:32], zero
   input  logic [bse_pkg::OP_W-1:0]     req_tuser,  // op [2:0]
   // Response channel.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bse_pkg::VALUE_W-1:0]  rsp_tdata,  // data [31:0]
   output logic [bse_pkg::STATUS_W-1:0] rsp_tuser,  // status [1:0]
   output logic                         rsp_tlast,
   // Capacity register.
   input  logic                         csr_wen,
   input  logic [bse_pkg::CAP_W-1:0]    csr_wdata
);

   bse_pkg::cmd_type cmd;
   bse_pkg::sts_type sts;

   bse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bse_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_op     (req_tuser),
      .req_value  (req_tdata[31:0]),
      .req_index  (req_tdata[37:32]),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_status (rsp_tuser),
      .rsp_last   (rsp_tlast)
   );

   // A result word is only loaded when the response register has room.
   `BSE_ASSERT_SAME(a_emit_room, cmd.emit, sts.out_free, "result word overwrites a pending one")
   // A push is only carried out below the effective capacity.
   `BSE_ASSERT_SAME(a_push_room, cmd.push, !sts.full && !sts.empty || !sts.full, "push while full")
   // A dump never steps the read pointer below the bottom entry.
   `BSE_ASSERT_SAME(a_dump_bottom, cmd.rd_next, !sts.ptr_zero, "dump read wraps past bottom")
   // Once a request is taken, no second one is taken in the next cycle.
   `BSE_ASSERT_NEXT(a_one_held, req_tvalid && req_tready, !req_tready, "second request taken")

endmodule
